[src/dcpn_pkg.sv]
`timescale 1ns / 1ps
// Package for the daisy-chain PWM command node: item types, operation codes,
// waveform constants and the period table. No dependencies.
package dcpn_pkg;

   // Input item of the request channel.
   typedef struct packed {
      logic       mode;
      logic [7:0] rx_byte;
      logic       rx_ninth_bit;
   } req_payload_type;

   // Result item of the response channel.
   typedef struct packed {
      logic        tx_valid;
      logic [7:0]  tx_byte;
      logic        tx_ninth_bit;
      logic        led_on;
      logic        drive_on;
      logic [6:0]  period_count;
      logic        polarity_b;
      logic [14:0] compare_value;
   } rsp_payload_type;

   // Item classes decided by the front end.
   typedef enum logic [2:0] {
      OP_TICK,
      OP_DROP,
      OP_FORWARD,
      OP_SELF,
      OP_DATA
   } op_type;

   // One queue entry between the front end and the back end.
   typedef struct packed {
      op_type     op;
      logic [7:0] tx_byte;
      logic       tx_ninth_bit;
   } entry_type;

   // Input modes.
   localparam logic MODE_BYTE = 1'b0;
   localparam logic MODE_TICK = 1'b1;

   // Waveform constants.
   localparam logic [4:0]  HALF_MARK   = 5'd15;
   localparam logic [14:0] LOW_COMPARE = 15'd64;

   // State after reset.
   localparam logic [3:0] DUTY_RESET = 4'd7;
   localparam logic [2:0] FREQ_RESET = 3'd3;

   // Period register value for each frequency level.
   function automatic logic [6:0] period_lookup(input logic [2:0] level);
      logic [6:0] value;
      case (level)
         3'd0:    value = 7'd127;
         3'd1:    value = 7'd107;
         3'd2:    value = 7'd91;
         3'd3:    value = 7'd80;
         3'd4:    value = 7'd66;
         3'd5:    value = 7'd56;
         3'd6:    value = 7'd48;
         3'd7:    value = 7'd40;
         default: value = 7'd127;
      endcase
      return value;
   endfunction

endpackage

[src/dcpn_stream_if.sv]
`timescale 1ns / 1ps
// Valid/ready stream interface used for the request and response channels.
// The payload type is given at instantiation; no other dependencies.
interface dcpn_stream_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

[src/dcpn_front.sv]
`timescale 1ns / 1ps
// Front end: takes request transfers, checks parity and classifies each item.
// Depends on dcpn_pkg and dcpn_stream_if.
module dcpn_front (
   dcpn_stream_if.sink         req_if,
   output logic                q_valid,
   input  logic                q_ready,
   output dcpn_pkg::entry_type q_entry
);
   import dcpn_pkg::*;

   logic [7:0] rx_byte;
   logic       parity_ok;
   logic [5:0] addr;
   logic [7:0] fwd_byte;

   // The queue decides when a transfer can be taken.
   assign q_valid      = req_if.valid;
   assign req_if.ready = q_ready;

   assign rx_byte   = req_if.data.rx_byte;
   assign parity_ok = ((^rx_byte) == req_if.data.rx_ninth_bit);
   assign addr      = rx_byte[6:1];
   assign fwd_byte  = {1'b0, addr - 6'd1, rx_byte[0]};

   // Classify the item and prepare the byte to be sent downstream.
   always_comb begin
      q_entry.tx_byte      = rx_byte;
      q_entry.tx_ninth_bit = req_if.data.rx_ninth_bit;
      if (req_if.data.mode == MODE_TICK) begin
         q_entry.op = OP_TICK;
      end else if (!parity_ok) begin
         q_entry.op = OP_DROP;
      end else if (rx_byte[7]) begin
         q_entry.op = OP_DATA;
      end else if (addr != 6'd0) begin
         q_entry.op           = OP_FORWARD;
         q_entry.tx_byte      = fwd_byte;
         q_entry.tx_ninth_bit = ^fwd_byte;
      end else begin
         q_entry.op = OP_SELF;
      end
   end

endmodule

[src/dcpn_queue.sv]
`timescale 1ns / 1ps
// Two-entry queue that decouples the front end from the back end.
// Depends on dcpn_pkg.
module dcpn_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  dcpn_pkg::entry_type in_entry,
   output logic                out_valid,
   input  logic                out_ready,
   output dcpn_pkg::entry_type out_entry
);
   import dcpn_pkg::*;

   entry_type  slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_entry = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_entry;
      end
   end

   // The fill count never exceeds the depth.
   assert property (@(posedge clock) disable iff (reset) count_ff <= 2'd2)
      else $error("queue count exceeds depth");

   // A lone push grows the count by one.
   assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + 2'd1)
      else $error("queue count did not grow on push");

   // A lone pop shrinks the count by one.
   assert property (@(posedge clock) disable iff (reset)
      pop && !push |=> count_ff == $past(count_ff) - 2'd1)
      else $error("queue count did not shrink on pop");

endmodule

[src/dcpn_back.sv]
`timescale 1ns / 1ps
// Back end: applies queued items to the node state and registers the result.
// Depends on dcpn_pkg and dcpn_stream_if.
module dcpn_back #(
   parameter int PHASE_STEPS = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   output logic                q_ready,
   input  dcpn_pkg::entry_type q_entry,
   dcpn_stream_if.source       rsp_if
);
   import dcpn_pkg::*;

   localparam int PHASE_W = $clog2(PHASE_STEPS);
   localparam int CMP_W   = (PHASE_W > 5) ? PHASE_W : 5;

   logic               selected_ff, selected_in;
   logic [3:0]         duty_ff, duty_in;
   logic [2:0]         freq_ff, freq_in;
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic               led_ff, led_in;
   logic               drive_ff, drive_in;
   logic               pol_ff, pol_in;
   logic [14:0]        cmp_ff, cmp_in;
   logic               out_valid_ff, out_valid_in;
   rsp_payload_type    out_ff, out_in;

   logic               apply;
   logic [CMP_W-1:0]   phase_x, duty_x, duty_half_x;

   // An item is applied whenever the output register is free or being emptied.
   assign apply   = q_valid && (!out_valid_ff || rsp_if.ready);
   assign q_ready = !out_valid_ff || rsp_if.ready;

   // Next phase and its comparisons, at a common width.
   always_comb begin
      if (phase_ff == PHASE_W'(PHASE_STEPS - 1)) begin
         phase_in = '0;
      end else begin
         phase_in = phase_ff + PHASE_W'(1);
      end
      phase_x     = CMP_W'(phase_in);
      duty_x      = CMP_W'(duty_ff);
      duty_half_x = CMP_W'(duty_ff) + CMP_W'(HALF_MARK);
   end

   // State update and result for the item at the head of the queue.
   always_comb begin
      selected_in = selected_ff;
      duty_in     = duty_ff;
      freq_in     = freq_ff;
      led_in      = led_ff;
      drive_in    = drive_ff;
      pol_in      = pol_ff;
      cmp_in      = cmp_ff;
      out_in.tx_valid     = 1'b0;
      out_in.tx_byte      = 8'd0;
      out_in.tx_ninth_bit = 1'b0;
      case (q_entry.op)
         OP_TICK: begin
            if (phase_x == '0 || phase_x == CMP_W'(HALF_MARK)) begin
               pol_in = 1'b0;
            end else if (phase_x == duty_x || phase_x == duty_half_x ||
                         duty_ff == 4'd0) begin
               pol_in = 1'b1;
            end
            if (phase_x < duty_x) begin
               cmp_in = {period_lookup(freq_ff), 8'd0};
            end else begin
               cmp_in = LOW_COMPARE;
            end
         end
         OP_FORWARD: begin
            selected_in         = 1'b0;
            out_in.tx_valid     = 1'b1;
            out_in.tx_byte      = q_entry.tx_byte;
            out_in.tx_ninth_bit = q_entry.tx_ninth_bit;
         end
         OP_SELF: begin
            led_in      = q_entry.tx_byte[0];
            selected_in = q_entry.tx_byte[0];
            if (!q_entry.tx_byte[0]) begin
               drive_in = 1'b0;
            end
         end
         OP_DATA: begin
            if (!selected_ff) begin
               out_in.tx_valid     = 1'b1;
               out_in.tx_byte      = q_entry.tx_byte;
               out_in.tx_ninth_bit = q_entry.tx_ninth_bit;
            end else begin
               freq_in     = q_entry.tx_byte[2:0];
               duty_in     = q_entry.tx_byte[6:3];
               drive_in    = 1'b1;
               selected_in = 1'b0;
            end
         end
         default: begin
            // A dropped byte leaves the state as it is.
         end
      endcase
      out_in.led_on        = led_in;
      out_in.drive_on      = drive_in;
      out_in.period_count  = period_lookup(freq_in);
      out_in.polarity_b    = pol_in;
      out_in.compare_value = cmp_in;
      out_valid_in = apply || (out_valid_ff && !rsp_if.ready);
   end

   // Node state and output valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         selected_ff  <= 1'b0;
         duty_ff      <= DUTY_RESET;
         freq_ff      <= FREQ_RESET;
         phase_ff     <= '0;
         led_ff       <= 1'b0;
         drive_ff     <= 1'b0;
         pol_ff       <= 1'b0;
         cmp_ff       <= 15'd0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (apply) begin
            selected_ff <= selected_in;
            duty_ff     <= duty_in;
            freq_ff     <= freq_in;
            led_ff      <= led_in;
            drive_ff    <= drive_in;
            pol_ff      <= pol_in;
            cmp_ff      <= cmp_in;
            if (q_entry.op == OP_TICK) begin
               phase_ff <= phase_in;
            end
         end
      end
   end

   // Result register holds payload only.
   always_ff @(posedge clock) begin
      if (apply) begin
         out_ff <= out_in;
      end
   end

   assign rsp_if.valid = out_valid_ff;
   assign rsp_if.data  = out_ff;

   // The phase moves only when a tick is applied.
   assert property (@(posedge clock) disable iff (reset)
      !(apply && q_entry.op == OP_TICK) |=> $stable(phase_ff))
      else $error("phase changed without a tick");

   // A dropped byte changes no control state.
   assert property (@(posedge clock) disable iff (reset)
      apply && q_entry.op == OP_DROP |=>
         $stable(selected_ff) && $stable(led_ff) && $stable(drive_ff))
      else $error("dropped byte changed node state");

   // A data byte taken while selected turns the drive on and deselects.
   assert property (@(posedge clock) disable iff (reset)
      apply && q_entry.op == OP_DATA && selected_ff |=> drive_ff && !selected_ff)
      else $error("selected data byte did not load the drive");

endmodule

[src/daisy_chain_pwm_command_node_top.sv]
`timescale 1ns / 1ps
// Daisy-chain PWM command node, top level. Path: the request transfer writes
// the queue, the back end applies the item at the queue head and registers
// its result, and a response stall can hold it there. Throughput: one item
// per cycle while the response side is ready. Reset (synchronous, active
// high) empties the queue and the result register and loads the node state:
// duty 7, frequency 3, all other state cleared.
// Depends on dcpn_pkg, dcpn_stream_if, dcpn_front, dcpn_queue and dcpn_back.
module daisy_chain_pwm_command_node_top #(
   parameter int PHASE_STEPS = 32
) (
   input  logic          clock,
   input  logic          reset,
   dcpn_stream_if.sink   req_if,
   dcpn_stream_if.source rsp_if
);
   import dcpn_pkg::*;

   logic      fq_valid, fq_ready;
   entry_type fq_entry;
   logic      qb_valid, qb_ready;
   entry_type qb_entry;

   // Classify incoming items.
   dcpn_front u_front (
      .req_if  (req_if),
      .q_valid (fq_valid),
      .q_ready (fq_ready),
      .q_entry (fq_entry)
   );

   // Buffer classified items.
   dcpn_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fq_valid),
      .in_ready  (fq_ready),
      .in_entry  (fq_entry),
      .out_valid (qb_valid),
      .out_ready (qb_ready),
      .out_entry (qb_entry)
   );

   // Apply items to the node state and deliver results.
   dcpn_back #(
      .PHASE_STEPS (PHASE_STEPS)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (qb_valid),
      .q_ready (qb_ready),
      .q_entry (qb_entry),
      .rsp_if  (rsp_if)
   );

endmodule

[bench/daisy_chain_pwm_command_node_top_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the daisy-chain PWM command node top level.
// Depends on dcpn_pkg, dcpn_stream_if and daisy_chain_pwm_command_node_top.
module daisy_chain_pwm_command_node_top_tb;
   import dcpn_pkg::*;

   localparam int PHASE_STEPS  = 32;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int HOLD_CYCLES  = 300;
   localparam int RANDOM_ITEMS = 1950;

   // Period register value per frequency level.
   localparam logic [6:0] PERIOD_BY_LEVEL [8] = '{
      7'd127, 7'd107, 7'd91, 7'd80, 7'd66, 7'd56, 7'd48, 7'd40
   };

   logic clock = 1'b0;
   logic reset;

   dcpn_stream_if #(.payload_type(req_payload_type)) req_if ();
   dcpn_stream_if #(.payload_type(rsp_payload_type)) rsp_if ();

   daisy_chain_pwm_command_node_top #(
      .PHASE_STEPS(PHASE_STEPS)
   ) DUT (
      .clock (clock),
      .reset (reset),
      .req_if(req_if),
      .rsp_if(rsp_if)
   );

   // Node state as seen by the predictor, loaded with the reset values.
   logic        node_selected = 1'b0;
   logic [3:0]  node_duty     = DUTY_RESET;
   logic [2:0]  node_freq     = FREQ_RESET;
   int          node_phase    = 0;
   logic        node_led      = 1'b0;
   logic        node_drive    = 1'b0;
   logic        node_polarity = 1'b0;
   logic [14:0] node_compare  = '0;

   rsp_payload_type expected_results [$];
   int  error_count = 0;
   int  items_sent  = 0;
   int  cycle_count = 0;
   bit  idle_enable = 1'b0;
   logic holding_off;
   event start_response_stall;

   // Free-running clock, 10 ns period.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Run limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Applies one item to the node state and returns the result it produces.
   function automatic rsp_payload_type predict_node(input req_payload_type item);
      rsp_payload_type result;
      logic [5:0] address;
      logic       start;
      result = '0;
      if (item.mode == MODE_TICK) begin
         // Waveform tick: advance the phase, then update polarity and compare.
         node_phase = (node_phase + 1) % PHASE_STEPS;
         if (node_phase == 0 || node_phase == int'(HALF_MARK))
            node_polarity = 1'b0;
         else if (node_phase == int'(node_duty) ||
                  node_phase == int'(node_duty) + int'(HALF_MARK) || node_duty == 0)
            node_polarity = 1'b1;
         if (node_phase < int'(node_duty))
            node_compare = {PERIOD_BY_LEVEL[node_freq], 8'h00};
         else
            node_compare = LOW_COMPARE;
      end else if ((^item.rx_byte) == item.rx_ninth_bit) begin
         if (!item.rx_byte[7]) begin
            address = item.rx_byte[6:1];
            start   = item.rx_byte[0];
            if (address != 0) begin
               // Someone further down the chain: pass it on one step closer.
               node_selected       = 1'b0;
               result.tx_valid     = 1'b1;
               result.tx_byte      = {1'b0, 6'(address - 6'd1), start};
               result.tx_ninth_bit = ^result.tx_byte;
            end else begin
               node_led      = start;
               node_selected = start;
               if (!start)
                  node_drive = 1'b0;
            end
         end else if (!node_selected) begin
            result.tx_valid     = 1'b1;
            result.tx_byte      = item.rx_byte;
            result.tx_ninth_bit = item.rx_ninth_bit;
         end else begin
            node_freq     = item.rx_byte[2:0];
            node_duty     = item.rx_byte[6:3];
            node_drive    = 1'b1;
            node_selected = 1'b0;
         end
      end
      result.led_on        = node_led;
      result.drive_on      = node_drive;
      result.period_count  = PERIOD_BY_LEVEL[node_freq];
      result.polarity_b    = node_polarity;
      result.compare_value = node_compare;
      return result;
   endfunction

   function automatic string describe_result(input rsp_payload_type r);
      return $sformatf("tx=%0b/%02h/%0b led=%0b drive=%0b period=%0d pol=%0b cmp=%0d",
                       r.tx_valid, r.tx_byte, r.tx_ninth_bit, r.led_on, r.drive_on,
                       r.period_count, r.polarity_b, r.compare_value);
   endfunction

   // Serial byte item, with the ninth bit right or deliberately wrong.
   function automatic req_payload_type byte_item(input logic [7:0] b, input bit parity_ok);
      return req_payload_type'{mode: MODE_BYTE, rx_byte: b,
                               rx_ninth_bit: parity_ok ? ^b : ~^b};
   endfunction

   // Tick item; the byte fields carry junk that the node must ignore.
   function automatic req_payload_type tick_item();
      return req_payload_type'{mode: MODE_TICK, rx_byte: 8'($urandom),
                               rx_ninth_bit: 1'($urandom)};
   endfunction

   // Offers one item, waits for its transfer and records the expected result.
   // Called at a rising edge; valid stays high for back-to-back items.
   task automatic send_item(input req_payload_type item);
      if (idle_enable && $urandom_range(99) < 6) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.data  <= item;
      do @(posedge clock); while (!req_if.ready);
      expected_results.push_back(predict_node(item));
      items_sent++;
   endtask

   // Response-side ready: random idling, or a long hold-off when requested.
   initial begin
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (reset || holding_off)
            rsp_if.ready <= 1'b0;
         else
            rsp_if.ready <= !(idle_enable && $urandom_range(99) < 6);
      end
   end

   // Counts out the long hold-off of the response side.
   initial begin
      holding_off <= 1'b0;
      forever begin
         @(start_response_stall);
         holding_off <= 1'b1;
         repeat (HOLD_CYCLES) @(posedge clock);
         holding_off <= 1'b0;
      end
   end

   // Compare every response transfer against the oldest prediction.
   always @(posedge clock) begin : check_results
      rsp_payload_type want;
      rsp_payload_type got;
      string bad;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got = rsp_if.data;
         if (expected_results.size() == 0) begin
            if (error_count < 10)
               $display("%0t: unexpected result %s", $realtime, describe_result(got));
            error_count++;
         end else begin
            want = expected_results.pop_front();
            bad = "";
            if (got.tx_valid      !== want.tx_valid)      bad = {bad, " tx_valid"};
            if (got.tx_byte       !== want.tx_byte)       bad = {bad, " tx_byte"};
            if (got.tx_ninth_bit  !== want.tx_ninth_bit)  bad = {bad, " tx_ninth_bit"};
            if (got.led_on        !== want.led_on)        bad = {bad, " led_on"};
            if (got.drive_on      !== want.drive_on)      bad = {bad, " drive_on"};
            if (got.period_count  !== want.period_count)  bad = {bad, " period_count"};
            if (got.polarity_b    !== want.polarity_b)    bad = {bad, " polarity_b"};
            if (got.compare_value !== want.compare_value) bad = {bad, " compare_value"};
            if (bad != "") begin
               if (error_count < 10)
                  $display("%0t: mismatch in%s\n   expected %s\n   actual   %s", $realtime,
                           bad, describe_result(want), describe_result(got));
               error_count++;
            end
         end
      end
   end

   // Address forwarding, self selection, data relay and parity drops.
   task automatic test_byte_routing();
      send_item(tick_item());
      send_item(byte_item(8'h00, 1'b1));   // own address, start clear
      send_item(byte_item(8'hFF, 1'b1));   // data while deselected: relayed
      send_item(byte_item(8'h80, 1'b0));   // bad parity on a data byte
      send_item(byte_item(8'h7F, 1'b1));   // highest address, start set
      send_item(byte_item(8'h02, 1'b1));   // address one becomes zero downstream
      send_item(byte_item(8'h01, 1'b1));   // own address, start set
      send_item(byte_item(8'h01, 1'b0));   // bad parity on an address byte
      send_item(byte_item(8'h01, 1'b1));   // reselect while already selected
      send_item(byte_item(8'h00, 1'b1));   // start clear turns the drive off
      send_item(byte_item(8'h80, 1'b1));   // relayed again
      send_item(byte_item(8'h01, 1'b1));
      send_item(byte_item(8'h03, 1'b1));   // forwarding deselects this node
      send_item(byte_item(8'hC5, 1'b1));   // so this data byte is relayed
   endtask

   // Duty and frequency extremes followed by a few ticks each.
   task automatic test_waveform_ticks();
      send_item(byte_item(8'h01, 1'b1));
      send_item(byte_item(8'h80, 1'b1));   // lowest frequency, zero duty
      repeat (4) send_item(tick_item());
      send_item(byte_item(8'h01, 1'b1));
      send_item(byte_item(8'hFF, 1'b1));   // highest frequency, full duty
      repeat (3) send_item(tick_item());
   endtask

   // The response side stops for a long time while requests keep coming.
   task automatic test_input_backpressure();
      idle_enable = 1'b0;
      -> start_response_stall;
      repeat (60) begin
         if ($urandom_range(1))
            send_item(tick_item());
         else
            send_item(byte_item(8'($urandom), 1'($urandom)));
      end
   endtask

   // Mostly well-formed commands and tick bursts, plus forwarding and noise.
   task automatic test_random_traffic(input int target);
      int kind;
      while (items_sent < target) begin
         // First stretch runs without any idling on either side.
         idle_enable = (items_sent > target / 4);
         kind = $urandom_range(99);
         if (kind < 40) begin
            send_item(byte_item(8'h01, 1'b1));
            send_item(byte_item({1'b1, 7'($urandom)}, 1'b1));
            repeat ($urandom_range(1, 40)) send_item(tick_item());
         end else if (kind < 60) begin
            send_item(tick_item());
         end else if (kind < 72) begin
            send_item(byte_item({1'b0, 7'($urandom)}, 1'b1));
         end else if (kind < 80) begin
            send_item(byte_item({7'b0, 1'($urandom)}, 1'b1));
         end else if (kind < 88) begin
            send_item(byte_item({1'b1, 7'($urandom)}, 1'b1));
         end else if (kind < 94) begin
            send_item(byte_item(8'($urandom), 1'b0));
         end else begin
            send_item(req_payload_type'(10'($urandom)));
         end
      end
   endtask

   initial begin
      reset        <= 1'b1;
      req_if.valid <= 1'b0;
      req_if.data  <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_byte_routing();
      test_waveform_ticks();
      test_input_backpressure();
      test_random_traffic(RANDOM_ITEMS);

      // Drain the pipeline, then allow a few cycles for stray results.
      req_if.valid <= 1'b0;
      idle_enable = 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

[filelist.f]
src/dcpn_pkg.sv
src/dcpn_stream_if.sv
src/dcpn_front.sv
src/dcpn_queue.sv
src/dcpn_back.sv
src/daisy_chain_pwm_command_node_top.sv
bench/daisy_chain_pwm_command_node_top_tb.sv
